// ----- rtl/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and codes of the connection pool table: entry layout,
// request modes, response status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// request modes
	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_CLEANUP = 2'd2;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	// response status codes
	localparam logic [2:0] ST_REUSED    = 3'd0;
	localparam logic [2:0] ST_NEW       = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_RELEASED  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_EVICTED   = 3'd5;
	localparam logic [2:0] ST_NONE      = 3'd6;

	// configuration register indexes
	localparam logic CFG_MAX_ENTRIES = 1'b0;
	localparam logic CFG_IDLE_LIMIT  = 1'b1;

	localparam logic [4:0]  MAX_ENTRIES_RST = 5'd10;
	localparam logic [21:0] IDLE_LIMIT_RST  = 22'd30000;

	typedef struct packed {
		logic [63:0] host;
		logic [15:0] port;
		logic [15:0] handle;
		logic [31:0] stamp;
		logic        busy;
	} entry_t;

	typedef struct packed {
		logic [4:0]  max_entries;
		logic [21:0] idle_limit_ms;
	} cfg_t;

endpackage

// ----- rtl/cpt_if.sv -----
// ----------------------------------------------------------------------------
// cpt_if
// Valid/ready channels of the connection pool table: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface cpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] host_key;
	logic [15:0] port;
	logic [15:0] handle;
	logic [31:0] now_ms;

	modport source (output valid, mode, host_key, port, handle, now_ms, input ready);
	modport sink (input valid, mode, host_key, port, handle, now_ms, output ready);
endinterface

interface cpt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] handle_out;
	logic        last;

	modport source (output valid, status, handle_out, last, input ready);
	modport sink (input valid, status, handle_out, last, output ready);
endinterface

interface cpt_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [21:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/cpt_ram.sv -----
// ----------------------------------------------------------------------------
// cpt_ram
// Generic single-clock RAM: one write port, one read port with registered
// read data, held while no read is issued.
// ----------------------------------------------------------------------------
module cpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpt_ctrl
// Sequencer of the connection pool table: scans the entry RAM one entry at a
// time, updates or appends entries, compacts the table on cleanup and drives
// the response output register.
// ----------------------------------------------------------------------------
module cpt_ctrl
	import cpt_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	cpt_req_if.sink         req,
	cpt_rsp_if.source       rsp,
	output logic            ram_we,
	output logic [AW-1:0]   ram_waddr,
	output entry_t          ram_wdata,
	output logic            ram_re,
	output logic [AW-1:0]   ram_raddr,
	input  entry_t          ram_rdata
);

	localparam int LW = (CW > 5) ? CW : 5;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EV   = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]    state_q, ret_q;
	logic [CW-1:0] idx_q, wr_q, live_q;
	logic [15:0]   next_h_q;
	logic [1:0]    mode_q;
	logic [63:0]   host_q;
	logic [15:0]   port_q;
	logic [15:0]   hnd_q;
	logic [31:0]   now_q;
	logic          pend_q;
	logic [15:0]   pend_h_q;
	logic [2:0]    res_status_q;
	logic [15:0]   res_h_q;
	logic          res_last_q;
	logic          out_vld_q;
	logic [2:0]    out_status_q;
	logic [15:0]   out_h_q;
	logic          out_last_q;

	logic          can_emit;
	logic          scan_end;
	logic          room;
	logic [LW-1:0] max_ext, limit;
	logic [31:0]   age;
	logic          acq_hit, rel_hit, evict;

	assign can_emit = !out_vld_q || rsp.ready;
	assign scan_end = (idx_q == live_q);

	assign max_ext = LW'(cfg.max_entries);
	assign limit   = (max_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : max_ext;
	assign room    = LW'(live_q) < limit;

	assign age     = now_q - ram_rdata.stamp;
	assign acq_hit = !ram_rdata.busy && (ram_rdata.host == host_q) && (ram_rdata.port == port_q);
	assign rel_hit = (ram_rdata.handle == hnd_q);
	assign evict   = !ram_rdata.busy && (age > 32'(cfg.idle_limit_ms));

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_status_q;
	assign rsp.handle_out = out_h_q;
	assign rsp.last       = out_last_q;

	assign ram_re    = (state_q == S_RD) && !scan_end;
	assign ram_raddr = idx_q[AW-1:0];

	// RAM write port: append, in-place update, or compaction move
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_RD: begin
				if (scan_end && mode_q == MODE_ACQUIRE && room) begin
					ram_we           = 1'b1;
					ram_waddr        = live_q[AW-1:0];
					ram_wdata.host   = host_q;
					ram_wdata.port   = port_q;
					ram_wdata.handle = next_h_q;
					ram_wdata.stamp  = now_q;
					ram_wdata.busy   = 1'b1;
				end
			end
			S_EV: begin
				case (mode_q)
					MODE_ACQUIRE: begin
						ram_we          = acq_hit;
						ram_wdata.stamp = now_q;
						ram_wdata.busy  = 1'b1;
					end
					MODE_RELEASE: begin
						ram_we         = rel_hit;
						ram_wdata.busy = 1'b0;
					end
					default: begin
						ram_we    = !evict && (wr_q != idx_q);
						ram_waddr = wr_q[AW-1:0];
					end
				endcase
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			idx_q        <= '0;
			wr_q         <= '0;
			live_q       <= '0;
			next_h_q     <= '0;
			pend_q       <= 1'b0;
			pend_h_q     <= '0;
			res_status_q <= ST_NONE;
			res_h_q      <= '0;
			res_last_q   <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			// load a new word or drop the one just taken
			if (state_q == S_EMIT && can_emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q  <= '0;
						wr_q   <= '0;
						pend_q <= 1'b0;
						if (req.mode != MODE_UNUSED) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (scan_end) begin
						state_q    <= S_EMIT;
						ret_q      <= S_IDLE;
						res_last_q <= 1'b1;
						case (mode_q)
							MODE_ACQUIRE: begin
								if (room) begin
									live_q       <= live_q + CW'(1);
									next_h_q     <= next_h_q + 16'd1;
									res_status_q <= ST_NEW;
									res_h_q      <= next_h_q;
								end else begin
									res_status_q <= ST_FULL;
									res_h_q      <= '0;
								end
							end
							MODE_RELEASE: begin
								res_status_q <= ST_NOT_FOUND;
								res_h_q      <= '0;
							end
							default: begin
								live_q <= wr_q;
								if (pend_q) begin
									res_status_q <= ST_EVICTED;
									res_h_q      <= pend_h_q;
								end else begin
									res_status_q <= ST_NONE;
									res_h_q      <= '0;
								end
							end
						endcase
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					idx_q <= idx_q + CW'(1);
					case (mode_q)
						MODE_ACQUIRE: begin
							if (acq_hit) begin
								state_q      <= S_EMIT;
								ret_q        <= S_IDLE;
								res_status_q <= ST_REUSED;
								res_h_q      <= ram_rdata.handle;
								res_last_q   <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
						MODE_RELEASE: begin
							if (rel_hit) begin
								state_q      <= S_EMIT;
								ret_q        <= S_IDLE;
								res_status_q <= ST_RELEASED;
								res_h_q      <= hnd_q;
								res_last_q   <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
						default: begin
							if (evict) begin
								// hold this eviction; the previous one is now known not last
								pend_q   <= 1'b1;
								pend_h_q <= ram_rdata.handle;
								if (pend_q) begin
									state_q      <= S_EMIT;
									ret_q        <= S_RD;
									res_status_q <= ST_EVICTED;
									res_h_q      <= pend_h_q;
									res_last_q   <= 1'b0;
								end else begin
									state_q <= S_RD;
								end
							end else begin
								wr_q    <= wr_q + CW'(1);
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_EMIT: begin
					if (can_emit) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and response payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			mode_q <= req.mode;
			host_q <= req.host_key;
			port_q <= req.port;
			hnd_q  <= req.handle;
			now_q  <= req.now_ms;
		end
		if (state_q == S_EMIT && can_emit) begin
			out_status_q <= res_status_q;
			out_h_q      <= res_h_q;
			out_last_q   <= res_last_q;
		end
	end

endmodule

// ----- rtl/connection_pool_table.sv -----
// ----------------------------------------------------------------------------
// connection_pool_table
// Ordered pool of connections keyed by host key and port, held in one entry
// RAM: acquire, release and idle cleanup with in-place compaction.
//
//   channel  dir  words carry
//   -------  ---  ----------------------------------------------
//   req      in   mode, host_key, port, handle, now_ms
//   rsp      out  status, handle_out, last
//   cfg      in   index (0 max_entries, 1 idle_limit_ms), data
//
// Each entry scanned passes through a read state and an evaluate state; the
// scan ends after the last entry, or at a hit for acquire and release;
// cleanup adds an emit state per eviction but the last; an ignored mode is
// taken with no response word. The registered read data of the entry RAM
// paces the scan. Reset acts only on the control state, the entry count and
// the limits; RAM entries past the count are never read, so there is no
// clearing pass. A held response word stalls the sequencer before it can
// produce the next one; a new request is taken while the last one waits.
// ----------------------------------------------------------------------------
module connection_pool_table
	import cpt_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	cpt_req_if.sink  req,
	cpt_rsp_if.source rsp,
	cpt_cfg_if.sink  cfg
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	cfg_t          cfg_q;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_entries   <= MAX_ENTRIES_RST;
			cfg_q.idle_limit_ms <= IDLE_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAX_ENTRIES: cfg_q.max_entries   <= cfg.data[4:0];
				CFG_IDLE_LIMIT:  cfg_q.idle_limit_ms <= cfg.data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	cpt_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	cpt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- dv/pool_table_checker.sv -----
// ----------------------------------------------------------------------------
// pool_table_checker
// Watches the request, response and configuration channels of the connection
// pool table. Keeps its own copy of the table and the limits, works out the
// response words of every accepted request and compares each accepted
// response word with the oldest one still due.
// ----------------------------------------------------------------------------
module pool_table_checker
	import cpt_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	cpt_req_if   req,
	cpt_rsp_if   rsp,
	cpt_cfg_if   cfg,
	output int   errors,
	output int   waiting
);

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] handle;
		logic        last;
	} pool_word_t;

	logic [63:0] slot_host   [SLOTS];
	logic [15:0] slot_port   [SLOTS];
	logic [15:0] slot_handle [SLOTS];
	logic [31:0] slot_stamp  [SLOTS];
	logic        slot_busy   [SLOTS];
	int          live;
	logic [15:0] handle_ctr;
	logic [4:0]  lim_entries;
	logic [21:0] lim_idle;

	pool_word_t due_q[$];
	int         mism;

	function void owe_word(input logic [2:0] st, input logic [15:0] hd, input logic lst);
		pool_word_t w;
		w.status = st;
		w.handle = hd;
		w.last   = lst;
		due_q.insert(due_q.size(), w);
	endfunction

	function void predict_request(input logic [1:0] m, input logic [63:0] hk,
			input logic [15:0] pt, input logic [15:0] hd, input logic [31:0] tm);
		int          cap;
		int          i;
		int          j;
		int          n;
		logic        found;
		logic [31:0] age;
		logic [15:0] gone [SLOTS];
		cap = (lim_entries > SLOTS) ? SLOTS : int'(lim_entries);
		found = 1'b0;
		n = 0;
		case (m)
			MODE_ACQUIRE: begin
				for (i = 0; i < live && !found; i++) begin
					if (!slot_busy[i] && slot_host[i] == hk && slot_port[i] == pt) begin
						slot_busy[i]  = 1'b1;
						slot_stamp[i] = tm;
						owe_word(ST_REUSED, slot_handle[i], 1'b1);
						found = 1'b1;
					end
				end
				if (!found) begin
					if (live < cap) begin
						slot_host[live]   = hk;
						slot_port[live]   = pt;
						slot_handle[live] = handle_ctr;
						slot_stamp[live]  = tm;
						slot_busy[live]   = 1'b1;
						live++;
						owe_word(ST_NEW, handle_ctr, 1'b1);
						handle_ctr = handle_ctr + 16'd1;
					end else begin
						owe_word(ST_FULL, 16'd0, 1'b1);
					end
				end
			end
			MODE_RELEASE: begin
				for (i = 0; i < live && !found; i++) begin
					if (slot_handle[i] == hd) begin
						slot_busy[i] = 1'b0;
						owe_word(ST_RELEASED, hd, 1'b1);
						found = 1'b1;
					end
				end
				if (!found)
					owe_word(ST_NOT_FOUND, 16'd0, 1'b1);
			end
			MODE_CLEANUP: begin
				i = 0;
				while (i < live) begin
					age = tm - slot_stamp[i];
					if (!slot_busy[i] && age > {10'd0, lim_idle}) begin
						gone[n] = slot_handle[i];
						n++;
						// close the gap, keep order
						for (j = i; j + 1 < live; j++) begin
							slot_host[j]   = slot_host[j + 1];
							slot_port[j]   = slot_port[j + 1];
							slot_handle[j] = slot_handle[j + 1];
							slot_stamp[j]  = slot_stamp[j + 1];
							slot_busy[j]   = slot_busy[j + 1];
						end
						live--;
					end else begin
						i++;
					end
				end
				if (n == 0)
					owe_word(ST_NONE, 16'd0, 1'b1);
				for (i = 0; i < n; i++)
					owe_word(ST_EVICTED, gone[i], i == n - 1);
			end
			default: begin
				// unused mode: no word
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pool_word_t want;
		if (!arst_n) begin
			live        = 0;
			handle_ctr  = 16'd0;
			lim_entries = MAX_ENTRIES_RST;
			lim_idle    = IDLE_LIMIT_RST;
			mism        = 0;
			due_q.delete();
			errors  <= 0;
			waiting <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_MAX_ENTRIES)
					lim_entries = cfg.data[4:0];
				else
					lim_idle = cfg.data;
			end
			if (req.valid && req.ready)
				predict_request(req.mode, req.host_key, req.port, req.handle, req.now_ms);
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("%0t: response word with none due: status=%0d handle=%0d last=%0b",
							$realtime, rsp.status, rsp.handle_out, rsp.last);
				end else begin
					want = due_q.pop_front();
					if (rsp.status !== want.status || rsp.handle_out !== want.handle
							|| rsp.last !== want.last) begin
						mism++;
						if (mism <= 10)
							$display("%0t: mismatch: expected status=%0d handle=%0d last=%0b, got status=%0d handle=%0d last=%0b",
								$realtime, want.status, want.handle, want.last,
								rsp.status, rsp.handle_out, rsp.last);
					end
				end
			end
			errors  <= mism;
			waiting <= due_q.size();
		end
	end

endmodule

// ----- dv/tb_connection_pool_table.sv -----
// ----------------------------------------------------------------------------
// tb_connection_pool_table
// Drives the connection pool table with a directed opening (reuse, append,
// full, release hits and misses, idle and busy eviction, ignored mode) and
// then random phases under several limit settings, with random gaps on the
// request side and random stalls on the response side, but for calm phases.
// The checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_connection_pool_table;
	import cpt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cpt_req_if req_ch ();
	cpt_rsp_if rsp_ch ();
	cpt_cfg_if cfg_ch ();

	int errors;
	int waiting;
	int cycle_n = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	logic [63:0] host_pool [4];
	logic [15:0] port_pool [4];
	logic [31:0] clock_ms = 32'd0;
	int          issued = 0;

	connection_pool_table #(.MAX_ENTRIES(16)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	pool_table_checker #(.SLOTS(16)) pool_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.waiting (waiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// response side: stall in random bursts unless calm
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 8);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_request(input logic [1:0] m, input logic [63:0] hk,
			input logic [15:0] pt, input logic [15:0] hd, input logic [31:0] tm);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= m;
		req_ch.host_key <= hk;
		req_ch.port     <= pt;
		req_ch.handle   <= hd;
		req_ch.now_ms   <= tm;
		if (m == MODE_ACQUIRE)
			issued++;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// hold requests until every due word is out, then let a ignored word drain
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_limits(input logic [4:0] cap, input logic [21:0] idle);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_MAX_ENTRIES;
		cfg_ch.data  <= {17'd0, cap};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= CFG_IDLE_LIMIT;
		cfg_ch.data  <= idle;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [4:0] cap, input logic [21:0] idle,
			input int unsigned step, input int items, input bit quiet);
		int          sent;
		int          pick;
		logic [63:0] hk;
		logic [15:0] pt;
		logic [15:0] hd;
		drain();
		write_limits(cap, idle);
		calm = quiet;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 19);
			clock_ms = clock_ms + $urandom_range(0, step);
			hk = host_pool[$urandom_range(0, 3)];
			pt = port_pool[$urandom_range(0, 3)];
			hd = $urandom_range(0, 65535);
			if (pick < 9) begin
				if (pick == 0)
					hk = {$urandom, $urandom};
				send_request(MODE_ACQUIRE, hk, pt, hd, clock_ms);
			end else if (pick < 15) begin
				if (pick != 14)
					hd = $urandom_range(0, (issued > 65535) ? 65535 : issued);
				send_request(MODE_RELEASE, {$urandom, $urandom}, $urandom_range(0, 65535),
					hd, clock_ms);
			end else if (pick < 19) begin
				send_request(MODE_CLEANUP, {$urandom, $urandom}, $urandom_range(0, 65535),
					hd, clock_ms);
			end else begin
				// ignored word, does not count
				send_request(MODE_UNUSED, {$urandom, $urandom}, pt, hd, $urandom);
				sent--;
			end
			sent++;
		end
	endtask

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.mode     = MODE_ACQUIRE;
		req_ch.host_key = 64'd0;
		req_ch.port     = 16'd0;
		req_ch.handle   = 16'd0;
		req_ch.now_ms   = 32'd0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = CFG_MAX_ENTRIES;
		cfg_ch.data     = 22'd0;
		host_pool[0] = 64'd0;
		host_pool[1] = '1;
		host_pool[2] = {$urandom, $urandom};
		host_pool[3] = 64'h5A5A_C3C3_0F0F_9669;
		port_pool[0] = 16'd0;
		port_pool[1] = 16'hFFFF;
		port_pool[2] = 16'd80;
		port_pool[3] = 16'd443;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening under the reset limits
		send_request(MODE_ACQUIRE, 64'd0, 16'd0, 16'hFFFF, 32'd0);
		send_request(MODE_ACQUIRE, 64'd0, 16'd0, 16'd0, 32'd10);
		send_request(MODE_RELEASE, '1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
		send_request(MODE_ACQUIRE, 64'd0, 16'd0, 16'd7, 32'd20);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'hFFFF, 32'd0);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'd1, 32'd0);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'd1, 32'd0);
		send_request(MODE_CLEANUP, 64'd0, 16'd0, 16'd0, 32'd100);
		send_request(MODE_ACQUIRE, '1, 16'hFFFF, 16'd0, 32'd200);
		send_request(MODE_UNUSED, '1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(MODE_CLEANUP, 64'd0, 16'd0, 16'd0, 32'd30011);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'd0, 32'd0);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'd2, 32'd0);
		send_request(MODE_CLEANUP, 64'd0, 16'd0, 16'd0, 32'd30020);
		send_request(MODE_CLEANUP, 64'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
		send_request(MODE_ACQUIRE, '1, 16'hFFFF, 16'd0, 32'd300);

		// zero limit: nothing appends, the busy entry still releases
		drain();
		write_limits(5'd0, 22'd0);
		send_request(MODE_ACQUIRE, 64'd1, 16'd1, 16'd0, 32'd400);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'd3, 32'd0);
		send_request(MODE_ACQUIRE, '1, 16'hFFFF, 16'd0, 32'd500);
		send_request(MODE_RELEASE, 64'd0, 16'd0, 16'd3, 32'd0);
		send_request(MODE_CLEANUP, 64'd0, 16'd0, 16'd0, 32'd501);
		send_request(MODE_CLEANUP, 64'd0, 16'd0, 16'd0, 32'd502);

		run_phase(5'd31, 22'd0, 50, 50, 1'b0);
		clock_ms = 32'hFFFF_F000;
		run_phase(5'd16, 22'd1000, 300, 60, 1'b0);
		run_phase(5'd4, 22'd500, 200, 45, 1'b0);
		run_phase(5'd2, 22'd3600000, 100000, 40, 1'b1);
		run_phase(5'd16, 22'h3FFFFF, 5000000, 40, 1'b0);
		run_phase(5'd1, 22'd0, 20, 35, 1'b0);
		run_phase(5'd12, 22'd2000, 400, 50, 1'b1);

		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
